>>> src/crcv_pkg.sv
// Shared constants, codes, types and the pixel address function for the circle raster canvas block.
// No dependencies; the design files refer to it by scoped names, the bench files import it.
package crcv_pkg;

	localparam int MAX_SIDE  = 256;
	localparam int FRAC_BITS = 8;

	localparam int COORD_W = 24;
	localparam int CHAR_W  = 8;
	localparam int PIXF_W  = 8;
	localparam int CFG_W   = 9;
	localparam int CFG_IDX_W = 2;

	localparam int SIDE_W = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
	localparam int CNT_W  = $clog2(MAX_SIDE + 1);
	localparam int ADDR_W = 2 * SIDE_W;

	localparam int XS_W = SIDE_W + FRAC_BITS + 1;
	localparam int DX_W = ((XS_W > COORD_W) ? XS_W : COORD_W) + 1;
	localparam int SQ_W = 2 * DX_W;
	localparam int D2_W = SQ_W + 1;

	localparam int ONE = 1 << FRAC_BITS;
	localparam int BG_RESET = 32;

	localparam logic [1:0] KIND_CLEAR = 2'd0;
	localparam logic [1:0] KIND_DRAW  = 2'd1;
	localparam logic [1:0] KIND_READ  = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_BG     = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_PREP,
		ST_DRAW,
		ST_DRAIN,
		ST_RD_ADDR,
		ST_RD_DATA,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic              valid;
		logic [SIDE_W-1:0] x;
		logic [SIDE_W-1:0] y;
	} pix_t;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] addr;
		logic [CHAR_W-1:0] data;
	} wr_t;

	function automatic logic [ADDR_W-1:0] pix_addr(input logic [SIDE_W-1:0] x,
		input logic [SIDE_W-1:0] y);
		return {y, x};
	endfunction

endpackage

>>> src/crcv_canvas_ram.sv
// Canvas character memory: one write port, one read port, registered read.
// Depends on crcv_pkg for widths and the write port struct.
module crcv_canvas_ram (
	input  logic                         clk,
	input  crcv_pkg::wr_t                wr,
	input  logic [crcv_pkg::ADDR_W-1:0]  raddr,
	output logic [crcv_pkg::CHAR_W-1:0]  rdata
);

	logic [crcv_pkg::CHAR_W-1:0] mem [2**crcv_pkg::ADDR_W];

	always_ff @(posedge clk) begin
		if (wr.we) begin
			mem[wr.addr] <= wr.data;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> src/crcv_circle_test.sv
// Three-stage pixel test: offsets, squares, then sum and compare to the squared radii.
// Depends on crcv_pkg for widths and the pixel struct.
module crcv_circle_test (
	input  logic                               clk,
	input  logic                               arst_n,
	input  crcv_pkg::pix_t                     pix_in,
	input  logic signed [crcv_pkg::COORD_W-1:0] cx,
	input  logic signed [crcv_pkg::COORD_W-1:0] cy,
	input  logic [crcv_pkg::D2_W-1:0]          r2,
	input  logic [crcv_pkg::D2_W-1:0]          ri2,
	input  logic                               inner,
	output crcv_pkg::pix_t                     hit_out,
	output logic                               busy
);

	logic                                v_s1, v_s2, v_s3;
	logic [crcv_pkg::SIDE_W-1:0]         x_s1, y_s1, x_s2, y_s2, x_s3, y_s3;
	logic signed [crcv_pkg::DX_W-1:0]    dx_s1, dy_s1;
	logic signed [crcv_pkg::SQ_W-1:0]    sqx_s2, sqy_s2;
	logic                                hit_s3;
	logic signed [crcv_pkg::DX_W-1:0]    dx_d, dy_d;
	logic [crcv_pkg::D2_W-1:0]           d2;

	assign dx_d = $signed(crcv_pkg::DX_W'(pix_in.x) << crcv_pkg::FRAC_BITS)
		- crcv_pkg::DX_W'(cx);
	assign dy_d = $signed(crcv_pkg::DX_W'(pix_in.y) << crcv_pkg::FRAC_BITS)
		- crcv_pkg::DX_W'(cy);
	assign d2 = {1'b0, sqx_s2} + {1'b0, sqy_s2};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= pix_in.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		x_s1   <= pix_in.x;
		y_s1   <= pix_in.y;
		dx_s1  <= dx_d;
		dy_s1  <= dy_d;
		x_s2   <= x_s1;
		y_s2   <= y_s1;
		sqx_s2 <= dx_s1 * dx_s1;
		sqy_s2 <= dy_s1 * dy_s1;
		x_s3   <= x_s2;
		y_s3   <= y_s2;
		hit_s3 <= (d2 <= r2) && !(inner && (d2 <= ri2));
	end

	assign hit_out.valid = v_s3 && hit_s3;
	assign hit_out.x     = x_s3;
	assign hit_out.y     = y_s3;
	assign busy          = v_s1 || v_s2 || v_s3;

endmodule

>>> src/circle_raster_canvas_unit.sv
// Circle raster canvas: sequencer, configuration registers and result port.
// Depends on crcv_pkg, crcv_canvas_ram and crcv_circle_test.
//
// Usage: an item is taken at a rising edge with start high and busy low.
// kind selects clear (fill the used area with background_char), draw (one
// filled disc or outline ring) or read (one pixel). Each item yields one
// result: done is high for exactly one cycle with pixel_value and error_seen.
// The receiver cannot stall; results are simply shown for that one cycle.
// Clear and draw scan the used area; a draw with a negative radius only sets
// the error. The canvas memory has a single write port, so at most one pixel
// is written per cycle; the per-pixel test is a three-stage pipeline that is
// drained before done. busy stays high from acceptance through done.
// Configuration is written through cfg_we, cfg_index and cfg_data; the user
// must write it only while idle; the block itself does not enforce this. Reset
// sets width and height to the full side, the background to a space and
// clears the error flag; the canvas holds no defined data until a clear item.
module circle_raster_canvas_unit (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   start,
	output logic                                   busy,
	input  logic [1:0]                             kind,
	input  logic                                   filled,
	input  logic signed [crcv_pkg::COORD_W-1:0]    center_x,
	input  logic signed [crcv_pkg::COORD_W-1:0]    center_y,
	input  logic signed [crcv_pkg::COORD_W-1:0]    circle_radius,
	input  logic [crcv_pkg::CHAR_W-1:0]            paint,
	input  logic [crcv_pkg::PIXF_W-1:0]            pixel_x,
	input  logic [crcv_pkg::PIXF_W-1:0]            pixel_y,
	input  logic                                   cfg_we,
	input  logic [crcv_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [crcv_pkg::CFG_W-1:0]             cfg_data,
	output logic                                   done,
	output logic [crcv_pkg::CHAR_W-1:0]            pixel_value,
	output logic                                   error_seen
);

	crcv_pkg::state_t                    state_q, state_d;
	logic [crcv_pkg::CNT_W-1:0]          w_q, h_q;
	logic [crcv_pkg::CHAR_W-1:0]         bg_q, paint_q, value_q;
	logic                                err_q;
	logic [crcv_pkg::SIDE_W-1:0]         x_q, y_q, px_q, py_q;
	logic                                in_range_q, filled_q, inner_q;
	logic signed [crcv_pkg::COORD_W-1:0] cx_q, cy_q, r_q;
	logic [crcv_pkg::D2_W-1:0]           r2_q, ri2_q;
	logic                                accept, scan_en, last_x, last_y;
	logic signed [crcv_pkg::COORD_W:0]   rm;
	logic signed [crcv_pkg::SQ_W-1:0]    r_sq, rm_sq;
	crcv_pkg::pix_t                      pix_in, hit_out;
	crcv_pkg::wr_t                       wr;
	logic                                pipe_busy;
	logic [crcv_pkg::CHAR_W-1:0]         rdata;

	function automatic logic [crcv_pkg::CNT_W-1:0] clamp_side(
		input logic [crcv_pkg::CFG_W-1:0] v);
		logic [crcv_pkg::CNT_W-1:0] r;
		if (v == '0) begin
			r = crcv_pkg::CNT_W'(1);
		end else if (32'(v) > crcv_pkg::MAX_SIDE) begin
			r = crcv_pkg::CNT_W'(crcv_pkg::MAX_SIDE);
		end else begin
			r = crcv_pkg::CNT_W'(v);
		end
		return r;
	endfunction

	assign accept = start && !busy;
	assign last_x = crcv_pkg::CNT_W'(x_q) == (w_q - crcv_pkg::CNT_W'(1));
	assign last_y = crcv_pkg::CNT_W'(y_q) == (h_q - crcv_pkg::CNT_W'(1));
	assign rm     = {r_q[crcv_pkg::COORD_W-1], r_q} - (crcv_pkg::COORD_W + 1)'(crcv_pkg::ONE);
	assign r_sq   = r_q * r_q;
	assign rm_sq  = rm * rm;

	always_comb begin
		state_d      = state_q;
		scan_en      = 1'b0;
		pix_in.valid = 1'b0;
		pix_in.x     = x_q;
		pix_in.y     = y_q;
		done         = 1'b0;
		case (state_q)
			crcv_pkg::ST_IDLE: begin
				if (accept) begin
					case (kind)
						crcv_pkg::KIND_CLEAR: state_d = crcv_pkg::ST_CLEAR;
						crcv_pkg::KIND_DRAW: begin
							state_d = circle_radius[crcv_pkg::COORD_W-1] ?
								crcv_pkg::ST_FINISH : crcv_pkg::ST_PREP;
						end
						crcv_pkg::KIND_READ: state_d = crcv_pkg::ST_RD_ADDR;
						default: state_d = crcv_pkg::ST_FINISH;
					endcase
				end
			end
			crcv_pkg::ST_CLEAR: begin
				scan_en = 1'b1;
				if (last_x && last_y) begin
					state_d = crcv_pkg::ST_FINISH;
				end
			end
			crcv_pkg::ST_PREP: state_d = crcv_pkg::ST_DRAW;
			crcv_pkg::ST_DRAW: begin
				scan_en      = 1'b1;
				pix_in.valid = 1'b1;
				if (last_x && last_y) begin
					state_d = crcv_pkg::ST_DRAIN;
				end
			end
			crcv_pkg::ST_DRAIN: begin
				if (!pipe_busy) begin
					state_d = crcv_pkg::ST_FINISH;
				end
			end
			crcv_pkg::ST_RD_ADDR: state_d = crcv_pkg::ST_RD_DATA;
			crcv_pkg::ST_RD_DATA: state_d = crcv_pkg::ST_FINISH;
			crcv_pkg::ST_FINISH: begin
				done    = 1'b1;
				state_d = crcv_pkg::ST_IDLE;
			end
			default: state_d = crcv_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		if (state_q == crcv_pkg::ST_CLEAR) begin
			wr.we   = 1'b1;
			wr.addr = crcv_pkg::pix_addr(x_q, y_q);
			wr.data = bg_q;
		end else begin
			wr.we   = hit_out.valid;
			wr.addr = crcv_pkg::pix_addr(hit_out.x, hit_out.y);
			wr.data = paint_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= crcv_pkg::ST_IDLE;
			w_q     <= crcv_pkg::CNT_W'(crcv_pkg::MAX_SIDE);
			h_q     <= crcv_pkg::CNT_W'(crcv_pkg::MAX_SIDE);
			bg_q    <= crcv_pkg::CHAR_W'(crcv_pkg::BG_RESET);
			err_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				case (cfg_index)
					crcv_pkg::CFG_WIDTH:  w_q  <= clamp_side(cfg_data);
					crcv_pkg::CFG_HEIGHT: h_q  <= clamp_side(cfg_data);
					crcv_pkg::CFG_BG:     bg_q <= cfg_data[crcv_pkg::CHAR_W-1:0];
					default: ;
				endcase
			end
			if (accept && kind == crcv_pkg::KIND_DRAW && circle_radius[crcv_pkg::COORD_W-1]) begin
				err_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			x_q        <= '0;
			y_q        <= '0;
			value_q    <= '0;
			cx_q       <= center_x;
			cy_q       <= center_y;
			r_q        <= circle_radius;
			filled_q   <= filled;
			paint_q    <= paint;
			px_q       <= crcv_pkg::SIDE_W'(pixel_x);
			py_q       <= crcv_pkg::SIDE_W'(pixel_y);
			in_range_q <= (32'(pixel_x) < 32'(w_q)) && (32'(pixel_y) < 32'(h_q));
		end
		if (scan_en) begin
			if (last_x) begin
				x_q <= '0;
				y_q <= y_q + crcv_pkg::SIDE_W'(1);
			end else begin
				x_q <= x_q + crcv_pkg::SIDE_W'(1);
			end
		end
		if (state_q == crcv_pkg::ST_PREP) begin
			r2_q    <= crcv_pkg::D2_W'($unsigned(r_sq));
			ri2_q   <= crcv_pkg::D2_W'($unsigned(rm_sq));
			inner_q <= !filled_q && (32'(r_q) >= crcv_pkg::ONE);
		end
		if (state_q == crcv_pkg::ST_RD_DATA) begin
			value_q <= in_range_q ? rdata : '0;
		end
	end

	crcv_circle_test u_test (
		.clk     (clk),
		.arst_n  (arst_n),
		.pix_in  (pix_in),
		.cx      (cx_q),
		.cy      (cy_q),
		.r2      (r2_q),
		.ri2     (ri2_q),
		.inner   (inner_q),
		.hit_out (hit_out),
		.busy    (pipe_busy)
	);

	crcv_canvas_ram u_ram (
		.clk   (clk),
		.wr    (wr),
		.raddr (crcv_pkg::pix_addr(px_q, py_q)),
		.rdata (rdata)
	);

	assign busy        = state_q != crcv_pkg::ST_IDLE;
	assign pixel_value = value_q;
	assign error_seen  = err_q;

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("done held longer than one cycle");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy) else $error("block still busy after result");

	a_pipe_in_draw: assert property (@(posedge clk) disable iff (!arst_n)
		pipe_busy |-> (state_q == crcv_pkg::ST_DRAW || state_q == crcv_pkg::ST_DRAIN))
		else $error("pixel pipeline active outside a draw item");

	a_write_busy: assert property (@(posedge clk) disable iff (!arst_n)
		wr.we |-> busy) else $error("canvas written while idle");

	a_err_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		error_seen |=> error_seen) else $error("error flag cleared");

endmodule

>>> tb/sv/canvas_tracker.sv
`timescale 1ns / 100ps
// Canvas tracker: follows register writes and accepted items of the circle raster
// canvas unit, keeps its own canvas copy and checks every pixel_value/error_seen result.
// Depends on crcv_pkg only.
module canvas_tracker
	import crcv_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic                       busy,
	input  logic [1:0]                 kind,
	input  logic                       filled,
	input  logic signed [COORD_W-1:0]  center_x,
	input  logic signed [COORD_W-1:0]  center_y,
	input  logic signed [COORD_W-1:0]  circle_radius,
	input  logic [CHAR_W-1:0]          paint,
	input  logic [PIXF_W-1:0]          pixel_x,
	input  logic [PIXF_W-1:0]          pixel_y,
	input  logic                       cfg_we,
	input  logic [CFG_IDX_W-1:0]       cfg_index,
	input  logic [CFG_W-1:0]           cfg_data,
	input  logic                       done,
	input  logic [CHAR_W-1:0]          pixel_value,
	input  logic                       error_seen,
	output int                         pending,
	output int                         mismatches
);

	typedef struct packed {
		logic [CHAR_W-1:0] value;
		logic              err;
	} pixel_result_t;

	logic [CHAR_W-1:0] canvas [MAX_SIDE*MAX_SIDE];
	int                cols;
	int                rows;
	logic [CHAR_W-1:0] bg_char;
	logic              err_flag;
	pixel_result_t     awaited_results [$];

	function automatic int side_of(logic [CFG_W-1:0] v);
		if (v == 0)
			return 1;
		if (v > MAX_SIDE)
			return MAX_SIDE;
		return int'(v);
	endfunction

	function automatic void fill_canvas();
		for (int y = 0; y < rows; y++)
			for (int x = 0; x < cols; x++)
				canvas[ADDR_W'(y * MAX_SIDE + x)] = bg_char;
	endfunction

	function automatic void paint_circle(logic solid, longint cx, longint cy, longint r,
		logic [CHAR_W-1:0] ch);
		longint outer_sq;
		longint inner_sq;
		longint dx;
		longint dy;
		longint d2;
		logic   ring;
		outer_sq = r * r;
		inner_sq = (r - ONE) * (r - ONE);
		ring = !solid && (r >= ONE);
		for (int y = 0; y < rows; y++) begin
			dy = longint'(y) * ONE - cy;
			for (int x = 0; x < cols; x++) begin
				dx = longint'(x) * ONE - cx;
				d2 = dx * dx + dy * dy;
				if (d2 <= outer_sq && !(ring && d2 <= inner_sq))
					canvas[ADDR_W'(y * MAX_SIDE + x)] = ch;
			end
		end
	endfunction

	function automatic pixel_result_t predict_item();
		pixel_result_t res;
		res.value = '0;
		case (kind)
			KIND_CLEAR: fill_canvas();
			KIND_DRAW: begin
				if (circle_radius < 0)
					err_flag = 1'b1;
				else
					paint_circle(filled, longint'(center_x), longint'(center_y),
						longint'(circle_radius), paint);
			end
			KIND_READ: begin
				if (pixel_x < cols && pixel_y < rows)
					res.value = canvas[ADDR_W'(int'(pixel_y) * MAX_SIDE + int'(pixel_x))];
			end
			default: ;
		endcase
		res.err = err_flag;
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin : track
		pixel_result_t want;
		if (!arst_n) begin
			cols = MAX_SIDE;
			rows = MAX_SIDE;
			bg_char = CHAR_W'(BG_RESET);
			err_flag = 1'b0;
			awaited_results.delete();
			mismatches = 0;
		end else begin
			if (done) begin
				if (awaited_results.size() == 0) begin
					$error("result with no item outstanding: pixel_value %0d error_seen %0b",
						pixel_value, error_seen);
					mismatches++;
				end else begin
					want = awaited_results.pop_front();
					if (pixel_value !== want.value) begin
						$error("pixel_value: expected %0d, got %0d", want.value, pixel_value);
						mismatches++;
					end
					if (error_seen !== want.err) begin
						$error("error_seen: expected %0b, got %0b", want.err, error_seen);
						mismatches++;
					end
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					CFG_WIDTH:  cols = side_of(cfg_data);
					CFG_HEIGHT: rows = side_of(cfg_data);
					CFG_BG:     bg_char = cfg_data[CHAR_W-1:0];
					default: ;
				endcase
			end
			if (start && !busy)
				awaited_results.push_back(predict_item());
		end
		pending = awaited_results.size();
	end

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 100ps
// Top of the circle raster canvas regression: drives items and register writes
// into circle_raster_canvas_unit and gives the verdict from canvas_tracker.
// Depends on crcv_pkg, circle_raster_canvas_unit and canvas_tracker.
module testbench;
	import crcv_pkg::*;

	localparam logic [1:0]           KIND_NOP    = 2'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE   = 2'd3;
	localparam int                   PHASES      = 8;
	localparam int                   PHASE_ITEMS = 13;
	localparam int unsigned          CYCLE_LIMIT = 2_000_000;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      start = 1'b0;
	logic                      busy;
	logic [1:0]                kind = KIND_CLEAR;
	logic                      filled = 1'b0;
	logic signed [COORD_W-1:0] center_x = '0;
	logic signed [COORD_W-1:0] center_y = '0;
	logic signed [COORD_W-1:0] circle_radius = '0;
	logic [CHAR_W-1:0]         paint = '0;
	logic [PIXF_W-1:0]         pixel_x = '0;
	logic [PIXF_W-1:0]         pixel_y = '0;
	logic                      cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]      cfg_index = CFG_WIDTH;
	logic [CFG_W-1:0]          cfg_data = '0;
	logic                      done;
	logic [CHAR_W-1:0]         pixel_value;
	logic                      error_seen;
	int                        pending;
	int                        mismatches;
	int unsigned               cycle_count = 0;
	int                        used_cols = MAX_SIDE;
	int                        used_rows = MAX_SIDE;
	bit                        steady = 1'b0;

	circle_raster_canvas_unit dut (.*);
	canvas_tracker tracker (.*);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	function automatic int pick_gap();
		int roll;
		if (steady)
			return 0;
		roll = $urandom_range(0, 19);
		if (roll < 10)
			return 0;
		if (roll < 18)
			return $urandom_range(1, 3);
		return $urandom_range(10, 80);
	endfunction

	function automatic logic [COORD_W-1:0] fx(int whole, int frac);
		return COORD_W'(whole * ONE + frac);
	endfunction

	task automatic send_item(logic [1:0] k, logic f, logic [COORD_W-1:0] cx,
		logic [COORD_W-1:0] cy, logic [COORD_W-1:0] r, logic [CHAR_W-1:0] p,
		logic [PIXF_W-1:0] px, logic [PIXF_W-1:0] py);
		bit taken;
		int gap;
		kind <= k;
		filled <= f;
		center_x <= cx;
		center_y <= cy;
		circle_radius <= r;
		paint <= p;
		pixel_x <= px;
		pixel_y <= py;
		start <= 1'b1;
		taken = 1'b0;
		while (!taken) begin
			@(negedge clk);
			taken = !busy;
			@(posedge clk);
		end
		gap = pick_gap();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic read_pixel(logic [PIXF_W-1:0] px, logic [PIXF_W-1:0] py);
		send_item(KIND_READ, 1'($urandom_range(0, 1)), COORD_W'($urandom()),
			COORD_W'($urandom()), COORD_W'($urandom()), CHAR_W'($urandom()), px, py);
	endtask

	task automatic draw(logic f, logic [COORD_W-1:0] cx, logic [COORD_W-1:0] cy,
		logic [COORD_W-1:0] r, logic [CHAR_W-1:0] p);
		send_item(KIND_DRAW, f, cx, cy, r, p, PIXF_W'($urandom()), PIXF_W'($urandom()));
	endtask

	task automatic drain();
		start <= 1'b0;
		do @(negedge clk); while (pending != 0 || busy);
		@(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic configure(logic [CFG_W-1:0] w, logic [CFG_W-1:0] h,
		logic [CHAR_W-1:0] bg);
		drain();
		write_reg(CFG_WIDTH, w);
		write_reg(CFG_HEIGHT, h);
		write_reg(CFG_BG, bg);
		write_reg(CFG_SPARE, CFG_W'($urandom()));
		used_cols = (w == 0) ? 1 : (w > MAX_SIDE) ? MAX_SIDE : int'(w);
		used_rows = (h == 0) ? 1 : (h > MAX_SIDE) ? MAX_SIDE : int'(h);
	endtask

	task automatic random_draw();
		int span;
		int cx;
		int cy;
		int r;
		span = ((used_cols > used_rows) ? used_cols : used_rows) * ONE;
		if ($urandom_range(0, 11) == 0) begin
			cx = $urandom();
			cy = $urandom();
			r = $urandom();
		end else begin
			cx = int'($urandom_range(0, used_cols * ONE + 2 * ONE)) - ONE;
			cy = int'($urandom_range(0, used_rows * ONE + 2 * ONE)) - ONE;
			r = $urandom_range(0, span);
			// snap to whole pixels so boundary ties come up often
			if ($urandom_range(0, 2) == 0) begin
				cx = cx & ~(ONE - 1);
				cy = cy & ~(ONE - 1);
				r = r & ~(ONE - 1);
			end
		end
		draw(1'($urandom_range(0, 1)), cx[COORD_W-1:0], cy[COORD_W-1:0], r[COORD_W-1:0],
			CHAR_W'($urandom()));
	endtask

	task automatic random_item();
		int roll;
		roll = $urandom_range(0, 19);
		if (roll < 3)
			send_item(KIND_CLEAR, 1'($urandom_range(0, 1)), COORD_W'($urandom()),
				COORD_W'($urandom()), COORD_W'($urandom()), CHAR_W'($urandom()),
				PIXF_W'($urandom()), PIXF_W'($urandom()));
		else if (roll < 4)
			send_item(KIND_NOP, 1'($urandom_range(0, 1)), COORD_W'($urandom()),
				COORD_W'($urandom()), COORD_W'($urandom()), CHAR_W'($urandom()),
				PIXF_W'($urandom()), PIXF_W'($urandom()));
		else if (roll < 11)
			random_draw();
		else if (roll < 17)
			read_pixel(PIXF_W'($urandom_range(0, used_cols - 1)),
				PIXF_W'($urandom_range(0, used_rows - 1)));
		else
			read_pixel(PIXF_W'($urandom()), PIXF_W'($urandom()));
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// full canvas at reset settings; the clear defines every pixel
		send_item(KIND_CLEAR, 1'b0, '0, '0, '0, '0, '0, '0);
		read_pixel(8'd0, 8'd0);
		read_pixel(8'd255, 8'd255);
		draw(1'b1, fx(128, 0), fx(128, 0), fx(100, 128), "C");
		read_pixel(8'd128, 8'd128);
		read_pixel(8'd128, 8'd28);
		read_pixel(8'd0, 8'd0);

		configure(9'd20, 9'd12, 8'hFF);
		send_item(KIND_CLEAR, 1'b1, '1, '1, '1, '1, '1, '1);
		draw(1'b0, fx(10, 0), fx(6, 0), fx(5, 0), "c");
		read_pixel(8'd15, 8'd6);
		read_pixel(8'd10, 8'd6);
		draw(1'b0, fx(3, 0), fx(3, 0), fx(0, 128), 8'd1);
		read_pixel(8'd3, 8'd3);
		draw(1'b1, fx(17, 0), fx(2, 0), fx(0, 0), 8'd0);
		read_pixel(8'd17, 8'd2);
		read_pixel(8'd25, 8'd3);
		read_pixel(8'd3, 8'd200);
		send_item(KIND_NOP, 1'b1, '1, '1, '1, '1, '1, '1);
		draw(1'b1, 24'h800000, 24'h800000, 24'h7FFFFF, 8'hAA);
		draw(1'b0, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 8'h55);
		read_pixel(8'd0, 8'd0);
		draw(1'b1, fx(5, 0), fx(5, 0), 24'hFFFFFF, 8'h77);
		draw(1'b0, fx(5, 0), fx(5, 0), 24'h800000, 8'h88);
		read_pixel(8'd5, 8'd5);

		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: configure(9'd0, 9'd256, CHAR_W'($urandom()));
				1: configure(9'd511, 9'd1, CHAR_W'($urandom()));
				2: configure(9'd1, 9'd1, 8'd0);
				3: configure(9'd300, 9'd2, 8'd255);
				default: configure(CFG_W'($urandom_range(2, 24)), CFG_W'($urandom_range(2, 24)),
					CHAR_W'($urandom()));
			endcase
			steady = (ph % 3 == 2);
			repeat (PHASE_ITEMS) random_item();
		end

		drain();
		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
